FILE: hdl/gsd_pkg.sv
// Shared constants and code types for the grid signed distance evaluator.
`default_nettype none
package gsd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 10;
    localparam int SIZE_W    = 31;
    localparam int ORG_W     = 32;
    localparam int MODE_W    = 3;
    localparam int COORD_W   = 43;
    localparam int MAG_W     = 41;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int RAD_W     = 86;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int OUT_W     = 48;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;

    localparam logic signed [OUT_W-1:0] OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] HALF_VAL =
        {{(OUT_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_CUBE      = 3'd0,
        MODE_SPHERE    = 3'd1,
        MODE_TORUS     = 3'd2,
        MODE_SHELL     = 3'd3,
        MODE_ELLIPSOID = 3'd4
    } shape_mode_t;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_SIZE    = 2'd1,
        REG_SPACING = 2'd2,
        REG_ORIGIN  = 2'd3
    } cfg_reg_t;

endpackage
`default_nettype wire

FILE: hdl/gsd_coord.sv
// Two-stage position unit: index times spacing plus origin, then magnitude.
`default_nettype none
module gsd_coord
    import gsd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [IDX_W-1:0]        idx,
    input  wire logic [SIZE_W-1:0]       spacing,
    input  wire logic signed [ORG_W-1:0] origin,
    output logic [MAG_W-1:0]             mag
);

    logic [IDX_W+SIZE_W-1:0]    prod;
    logic signed [COORD_W-1:0]  pos_next;
    logic signed [COORD_W-1:0]  pos_reg;
    logic signed [COORD_W-1:0]  abs_val;
    logic [MAG_W-1:0]           mag_next;
    logic [MAG_W-1:0]           mag_reg;

    always_comb
    begin
        prod     = idx * spacing;
        pos_next = $signed({{(COORD_W-IDX_W-SIZE_W){1'b0}}, prod})
                 + $signed({{(COORD_W-ORG_W){origin[ORG_W-1]}}, origin});
        abs_val  = pos_reg[COORD_W-1] ? -pos_reg : pos_reg;
        mag_next = abs_val[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        mag_reg <= mag_next;
    end

    assign mag = mag_reg;

endmodule
`default_nettype wire

FILE: hdl/gsd_sqr.sv
// Two-stage squarer built from half-width partial products.
`default_nettype none
module gsd_sqr
    import gsd_pkg::*;
#(
    parameter int IN_W = MAG_W
)
(
    input  wire logic              clk,
    input  wire logic [IN_W-1:0]   a,
    output logic [2*IN_W-1:0]      sq
);

    localparam int LO_W = IN_W / 2;
    localparam int HI_W = IN_W - LO_W;

    logic [2*LO_W-1:0]      ll_next, ll_reg;
    logic [HI_W+LO_W-1:0]   hl_next, hl_reg;
    logic [2*HI_W-1:0]      hh_next, hh_reg;
    logic [2*IN_W-1:0]      sq_next, sq_reg;

    always_comb
    begin
        ll_next = a[LO_W-1:0] * a[LO_W-1:0];
        hl_next = a[IN_W-1:LO_W] * a[LO_W-1:0];
        hh_next = a[IN_W-1:LO_W] * a[IN_W-1:LO_W];
        // The cross term appears twice, hence the extra shift by one.
        sq_next = ((2*IN_W)'(hh_reg) << (2*LO_W))
                + ((2*IN_W)'(hl_reg) << (LO_W+1))
                + (2*IN_W)'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        ll_reg <= ll_next;
        hl_reg <= hl_next;
        hh_reg <= hh_next;
        sq_reg <= sq_next;
    end

    assign sq = sq_reg;

endmodule
`default_nettype wire

FILE: hdl/gsd_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side payload.
`default_nettype none
module gsd_sqrt
    import gsd_pkg::*;
#(
    parameter int RADICAND_W = RAD_W,
    parameter int SIDE_W     = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_vld,
    input  wire logic [RADICAND_W-1:0]   rad,
    input  wire logic [SIDE_W-1:0]       side_in,
    output logic                         out_vld,
    output logic [RADICAND_W/2-1:0]      root,
    output logic [SIDE_W-1:0]            side_out
);

    localparam int RT_W  = RADICAND_W / 2;
    localparam int REM_W = RT_W + 1;
    localparam int SH_W  = RT_W + 3;

    logic [RADICAND_W-1:0] rad_reg  [RT_W];
    logic [REM_W-1:0]      rem_reg  [RT_W];
    logic [RT_W-1:0]       root_reg [RT_W];
    logic [SIDE_W-1:0]     side_reg [RT_W];
    logic [RT_W-1:0]       vld_reg;
    logic [REM_W-1:0]      rem_next  [RT_W];
    logic [RT_W-1:0]       root_next [RT_W];

    // One restoring step: bring down two radicand bits and try a one.
    function automatic logic [REM_W+RT_W-1:0] sqrt_step(
        input logic [REM_W-1:0] rem_in,
        input logic [1:0]       pair,
        input logic [RT_W-1:0]  root_in
    );
        logic [SH_W-1:0] rem_sh;
        logic [SH_W-1:0] trial;
        logic [SH_W-1:0] dif;
        logic            ge;
        rem_sh = {rem_in, pair};
        trial  = {1'b0, root_in, 2'b01};
        dif    = rem_sh - trial;
        ge     = (rem_sh >= trial);
        return {(ge ? dif[REM_W-1:0] : rem_sh[REM_W-1:0]), root_in[RT_W-2:0], ge};
    endfunction

    always_comb
    begin
        {rem_next[0], root_next[0]} =
            sqrt_step('0, rad[RADICAND_W-1 -: 2], '0);
        for (int k = 1; k < RT_W; k++)
        begin
            {rem_next[k], root_next[k]} =
                sqrt_step(rem_reg[k-1], rad_reg[k-1][RADICAND_W-1 -: 2], root_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[RT_W-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg[0]  <= rad << 2;
        side_reg[0] <= side_in;
        for (int k = 1; k < RT_W; k++)
        begin
            rad_reg[k]  <= rad_reg[k-1] << 2;
            side_reg[k] <= side_reg[k-1];
        end
        for (int k = 0; k < RT_W; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign out_vld  = vld_reg[RT_W-1];
    assign root     = root_reg[RT_W-1];
    assign side_out = side_reg[RT_W-1];

endmodule
`default_nettype wire

FILE: hdl/grid_signed_distance_eval_unit.sv
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The latency is set by the two 43-stage square root pipelines in series (torus path).
// All shapes take the same path, so results leave in acceptance order.
// Reset (rst_n low, asynchronous) empties the pipeline and restores register defaults.
`default_nettype none
module grid_signed_distance_eval_unit
    import gsd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [IDX_W-1:0]        index_x,
    input  wire logic [IDX_W-1:0]        index_y,
    input  wire logic [IDX_W-1:0]        index_z,
    output logic                         done,
    output logic signed [OUT_W-1:0]      level_value,
    output logic                         saturated,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [CFG_AW-1:0]       paddr,
    input  wire logic [CFG_DW-1:0]       pwdata,
    output logic [CFG_DW-1:0]            prdata,
    output logic                         pready
);

    localparam int SIDE1_W = SQ_W + OUT_W + 1;
    localparam int SIDE2_W = OUT_W + 1;

    // Configuration registers.
    logic [MODE_W-1:0]        shape_mode_reg;
    logic [SIZE_W-1:0]        shape_size_reg;
    logic [SIZE_W-1:0]        grid_spacing_reg;
    logic signed [ORG_W-1:0]  grid_origin_reg;
    logic [2*SIZE_W-1:0]      size_sq_reg;
    logic signed [OUT_W-1:0]  size_val;
    logic                     cfg_wr;

    assign pready   = 1'b1;
    assign busy     = 1'b0;
    assign cfg_wr   = psel & penable & pwrite;
    assign size_val = $signed({{(OUT_W-SIZE_W){1'b0}}, shape_size_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg   <= MODE_CUBE;
            shape_size_reg   <= SIZE_W'(1 << FRAC_BITS);
            grid_spacing_reg <= SIZE_W'(1 << FRAC_BITS);
            grid_origin_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_reg_t'(paddr[3:2]))
                REG_MODE:    shape_mode_reg   <= pwdata[MODE_W-1:0];
                REG_SIZE:    shape_size_reg   <= pwdata[SIZE_W-1:0];
                REG_SPACING: grid_spacing_reg <= pwdata[SIZE_W-1:0];
                REG_ORIGIN:  grid_origin_reg  <= pwdata[ORG_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[3:2]))
            REG_MODE:    prdata = CFG_DW'(shape_mode_reg);
            REG_SIZE:    prdata = CFG_DW'(shape_size_reg);
            REG_SPACING: prdata = CFG_DW'(grid_spacing_reg);
            REG_ORIGIN:  prdata = grid_origin_reg;
            default:     prdata = '0;
        endcase
    end

    // The squared size follows the register; it settles long before an item needs it.
    always_ff @(posedge clk)
    begin
        size_sq_reg <= shape_size_reg * shape_size_reg;
    end

    // Stages 1 to 4: positions, magnitudes and squares per axis.
    logic [MAG_W-1:0] mag_x, mag_y, mag_z;
    logic [SQ_W-1:0]  sq_x, sq_y, sq_z;
    logic [MAG_W-1:0] max_next, max3_reg, max4_reg;
    logic             vld1_reg, vld2_reg, vld3_reg, vld4_reg;

    gsd_coord u_coord_x (.clk(clk), .idx(index_x), .spacing(grid_spacing_reg),
                         .origin(grid_origin_reg), .mag(mag_x));
    gsd_coord u_coord_y (.clk(clk), .idx(index_y), .spacing(grid_spacing_reg),
                         .origin(grid_origin_reg), .mag(mag_y));
    gsd_coord u_coord_z (.clk(clk), .idx(index_z), .spacing(grid_spacing_reg),
                         .origin(grid_origin_reg), .mag(mag_z));

    gsd_sqr #(.IN_W(MAG_W)) u_sqr_x (.clk(clk), .a(mag_x), .sq(sq_x));
    gsd_sqr #(.IN_W(MAG_W)) u_sqr_y (.clk(clk), .a(mag_y), .sq(sq_y));
    gsd_sqr #(.IN_W(MAG_W)) u_sqr_z (.clk(clk), .a(mag_z), .sq(sq_z));

    always_comb
    begin
        max_next = (mag_x > mag_y) ? mag_x : mag_y;
        if (mag_z > max_next)
        begin
            max_next = mag_z;
        end
    end

    // Stages 5 to 7: sums, quadric difference and the cube value.
    logic [RAD_W-1:0]         sxz5_reg, s35_reg, sell5_reg;
    logic [SQ_W-1:0]          y25_reg, y26_reg, y27_reg;
    logic signed [OUT_W-1:0]  cube_next, cube5_reg, cube6_reg;
    logic signed [OUT_W-1:0]  cube_t;
    logic [RAD_W-1:0]         rad6_reg, rad7_reg;
    logic [RAD_W-1:0]         quad_sum;
    logic signed [RAD_W:0]    diff6_reg;
    logic signed [RAD_W:0]    diff_shr;
    logic signed [OUT_W-1:0]  pre7_val_reg, pre_val_next;
    logic                     pre7_sat_reg, pre_sat_next;
    logic                     vld5_reg, vld6_reg, vld7_reg;

    always_comb
    begin
        cube_t    = ($signed({{(OUT_W-MAG_W){1'b0}}, max4_reg}) <<< 1) - size_val;
        // Halving by arithmetic shift rounds toward minus infinity.
        cube_next = cube_t >>> 1;
        quad_sum  = (shape_mode_reg == MODE_SPHERE) ? s35_reg : sell5_reg;
        diff_shr  = diff6_reg >>> FRAC_BITS;
        if (shape_mode_reg == MODE_CUBE)
        begin
            pre_val_next = cube6_reg;
            pre_sat_next = 1'b0;
        end
        else if (!diff_shr[RAD_W] && (diff_shr[RAD_W-1:OUT_W-1] != '0))
        begin
            pre_val_next = OUT_MAX;
            pre_sat_next = 1'b1;
        end
        else
        begin
            pre_val_next = diff_shr[OUT_W-1:0];
            pre_sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        max3_reg     <= max_next;
        max4_reg     <= max3_reg;
        sxz5_reg     <= RAD_W'(sq_x) + RAD_W'(sq_z);
        s35_reg      <= RAD_W'(sq_x) + RAD_W'(sq_y) + RAD_W'(sq_z);
        sell5_reg    <= (RAD_W'(sq_x) << 1) + (RAD_W'(sq_y) << 1) + RAD_W'(sq_y)
                      + RAD_W'(sq_z);
        y25_reg      <= sq_y;
        cube5_reg    <= cube_next;
        rad6_reg     <= (shape_mode_reg == MODE_TORUS) ? sxz5_reg : s35_reg;
        diff6_reg    <= $signed({1'b0, quad_sum})
                      - $signed({{(RAD_W+1-2*SIZE_W){1'b0}}, size_sq_reg});
        y26_reg      <= y25_reg;
        cube6_reg    <= cube5_reg;
        rad7_reg     <= rad6_reg;
        y27_reg      <= y26_reg;
        pre7_val_reg <= pre_val_next;
        pre7_sat_reg <= pre_sat_next;
    end

    // First square root: radius for the shell, ring distance for the torus.
    logic                     vld_s1;
    logic [ROOT_W-1:0]        root1;
    logic [SIDE1_W-1:0]       side1;
    logic [SQ_W-1:0]          y2_s1;
    logic signed [OUT_W-1:0]  pre_s1_val;
    logic                     pre_s1_sat;

    gsd_sqrt #(.RADICAND_W(RAD_W), .SIDE_W(SIDE1_W)) u_sqrt_a (
        .clk(clk), .rst_n(rst_n), .in_vld(vld7_reg), .rad(rad7_reg),
        .side_in({y27_reg, pre7_val_reg, pre7_sat_reg}),
        .out_vld(vld_s1), .root(root1), .side_out(side1)
    );

    assign {y2_s1, pre_s1_val, pre_s1_sat} = side1;

    // Stage after the first root: tube offset and the non-torus results.
    logic signed [OUT_W-1:0]  r_val, ring_off, ring_abs, near_d, far_d;
    logic signed [OUT_W-1:0]  oth_val_next;
    logic                     oth_sat_next;
    logic [ROOT_W-1:0]        qa_reg;
    logic [SQ_W-1:0]          y2t_reg, y2a_reg, y2b_reg;
    logic signed [OUT_W-1:0]  otht_val_reg, otha_val_reg, othb_val_reg, oth2_val_reg;
    logic                     otht_sat_reg, otha_sat_reg, othb_sat_reg, oth2_sat_reg;
    logic                     vldt_reg, vlda_reg, vldb_reg, vld2t_reg;
    logic [2*ROOT_W-1:0]      qa_sq;
    logic [RAD_W-1:0]         rad2_reg;

    always_comb
    begin
        r_val    = $signed({{(OUT_W-ROOT_W){1'b0}}, root1});
        ring_off = r_val - size_val;
        ring_abs = ring_off[OUT_W-1] ? -ring_off : ring_off;
        near_d   = r_val - HALF_VAL;
        far_d    = size_val - r_val;
        oth_sat_next = 1'b0;
        unique case (shape_mode_reg)
            MODE_CUBE, MODE_SPHERE, MODE_ELLIPSOID:
            begin
                oth_val_next = pre_s1_val;
                oth_sat_next = pre_s1_sat;
            end
            MODE_SHELL:
            begin
                if (r_val < HALF_VAL)
                begin
                    oth_val_next = HALF_VAL - r_val;
                end
                else if (r_val <= size_val)
                begin
                    oth_val_next = (near_d < far_d) ? -near_d : -far_d;
                end
                else
                begin
                    oth_val_next = r_val - size_val;
                end
            end
            default: oth_val_next = '0;
        endcase
    end

    gsd_sqr #(.IN_W(ROOT_W)) u_sqr_q (.clk(clk), .a(qa_reg), .sq(qa_sq));

    always_ff @(posedge clk)
    begin
        qa_reg       <= ring_abs[ROOT_W-1:0];
        y2t_reg      <= y2_s1;
        otht_val_reg <= oth_val_next;
        otht_sat_reg <= oth_sat_next;
        y2a_reg      <= y2t_reg;
        otha_val_reg <= otht_val_reg;
        otha_sat_reg <= otht_sat_reg;
        y2b_reg      <= y2a_reg;
        othb_val_reg <= otha_val_reg;
        othb_sat_reg <= otha_sat_reg;
        rad2_reg     <= RAD_W'(qa_sq) + RAD_W'(y2b_reg);
        oth2_val_reg <= othb_val_reg;
        oth2_sat_reg <= othb_sat_reg;
    end

    // Second square root: distance to the tube centre line.
    logic                     vld_s2;
    logic [ROOT_W-1:0]        root2;
    logic [SIDE2_W-1:0]       side2;
    logic signed [OUT_W-1:0]  fin_val;
    logic signed [OUT_W-1:0]  res_val_reg;
    logic                     res_sat_reg;
    logic                     done_reg;

    gsd_sqrt #(.RADICAND_W(RAD_W), .SIDE_W(SIDE2_W)) u_sqrt_b (
        .clk(clk), .rst_n(rst_n), .in_vld(vld2t_reg), .rad(rad2_reg),
        .side_in({oth2_val_reg, oth2_sat_reg}),
        .out_vld(vld_s2), .root(root2), .side_out(side2)
    );

    always_comb
    begin
        fin_val = $signed({{(OUT_W-ROOT_W){1'b0}}, root2}) - size_val + HALF_VAL;
    end

    always_ff @(posedge clk)
    begin
        if (shape_mode_reg == MODE_TORUS)
        begin
            res_val_reg <= fin_val;
            res_sat_reg <= 1'b0;
        end
        else
        begin
            res_val_reg <= side2[SIDE2_W-1:1];
            res_sat_reg <= side2[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg  <= 1'b0;
            vld2_reg  <= 1'b0;
            vld3_reg  <= 1'b0;
            vld4_reg  <= 1'b0;
            vld5_reg  <= 1'b0;
            vld6_reg  <= 1'b0;
            vld7_reg  <= 1'b0;
            vldt_reg  <= 1'b0;
            vlda_reg  <= 1'b0;
            vldb_reg  <= 1'b0;
            vld2t_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vld1_reg  <= start & ~busy;
            vld2_reg  <= vld1_reg;
            vld3_reg  <= vld2_reg;
            vld4_reg  <= vld3_reg;
            vld5_reg  <= vld4_reg;
            vld6_reg  <= vld5_reg;
            vld7_reg  <= vld6_reg;
            vldt_reg  <= vld_s1;
            vlda_reg  <= vldt_reg;
            vldb_reg  <= vlda_reg;
            vld2t_reg <= vldb_reg;
            done_reg  <= vld_s2;
        end
    end

    assign done        = done_reg;
    assign level_value = res_val_reg;
    assign saturated   = res_sat_reg;

endmodule
`default_nettype wire

FILE: verif/gsd_checker.sv
// Checker for the grid signed distance evaluator: predicts each result and compares.
`timescale 1ns / 1ps
module gsd_checker
    import gsd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [IDX_W-1:0]     index_x,
    input  wire logic [IDX_W-1:0]     index_y,
    input  wire logic [IDX_W-1:0]     index_z,
    input  wire logic                 done,
    input  wire logic [OUT_W-1:0]     level_value,
    input  wire logic                 saturated,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [CFG_AW-1:0]    paddr,
    input  wire logic [CFG_DW-1:0]    pwdata,
    input  wire logic                 pready,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [OUT_W-1:0] level;
        logic             sat;
    } level_result_t;

    level_result_t  level_queue[$];
    logic [2:0]     mode_q;
    logic [30:0]    size_q;
    logic [30:0]    spacing_q;
    logic [31:0]    origin_q;

    function automatic logic [63:0] int_sqrt(input logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int b = 62; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (({64'd0, t} * {64'd0, t}) <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] axis_mag(input logic [IDX_W-1:0] idx);
        longint c;
        c = longint'({54'd0, idx}) * longint'({33'd0, spacing_q})
            + longint'($signed(origin_q));
        return abs64(c);
    endfunction

    // Sum of squares less R squared, scaled back to Q16 with floor rounding.
    function automatic longint quad_level(input logic [127:0] s, inout logic sat);
        logic [127:0] r2;
        logic [127:0] d;
        r2 = {97'd0, size_q} * {97'd0, size_q};
        if (s >= r2)
        begin
            d = (s - r2) >> FRAC_BITS;
            if (d > 128'(OUT_MAX))
            begin
                sat = 1'b1;
                return longint'(OUT_MAX);
            end
            return longint'(d[63:0]);
        end
        d = r2 - s;
        return -longint'((d + 128'd65535) >> FRAC_BITS);
    endfunction

    function automatic level_result_t predict_level(input logic [IDX_W-1:0] ix,
                                                   input logic [IDX_W-1:0] iy,
                                                   input logic [IDX_W-1:0] iz);
        logic [63:0]    ax, ay, az, m, qa;
        logic [127:0]   x2, y2, z2;
        longint         v, sz, half, t, q, r;
        logic           sat;
        level_result_t  res;
        ax = axis_mag(ix);
        ay = axis_mag(iy);
        az = axis_mag(iz);
        x2 = {64'd0, ax} * {64'd0, ax};
        y2 = {64'd0, ay} * {64'd0, ay};
        z2 = {64'd0, az} * {64'd0, az};
        sz = longint'({33'd0, size_q});
        half = longint'(1) << (FRAC_BITS - 1);
        sat = 1'b0;
        v = 0;
        case (mode_q)
            MODE_CUBE:
            begin
                m = (ax > ay) ? ax : ay;
                if (az > m)
                    m = az;
                t = longint'(2 * m) - sz;
                v = t >>> 1;
            end
            MODE_SPHERE:
                v = quad_level(x2 + y2 + z2, sat);
            MODE_TORUS:
            begin
                q = longint'(int_sqrt(x2 + z2)) - sz;
                qa = abs64(q);
                v = longint'(int_sqrt({64'd0, qa} * {64'd0, qa} + y2)) - sz + half;
            end
            MODE_SHELL:
            begin
                r = longint'(int_sqrt(x2 + y2 + z2));
                if (r < half)
                    v = half - r;
                else if (r <= sz)
                    v = ((r - half) < (sz - r)) ? -(r - half) : -(sz - r);
                else
                    v = r - sz;
            end
            MODE_ELLIPSOID:
                v = quad_level(2 * x2 + 3 * y2 + z2, sat);
            default:
                v = 0;
        endcase
        res.level = v[OUT_W-1:0];
        res.sat = sat;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        level_result_t exp_res;
        if (!rst_n)
        begin
            mode_q <= MODE_CUBE;
            size_q <= 31'd65536;
            spacing_q <= 31'd65536;
            origin_q <= 32'd0;
            level_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                case (cfg_reg_t'(paddr[3:2]))
                    REG_MODE:    mode_q <= pwdata[2:0];
                    REG_SIZE:    size_q <= pwdata[30:0];
                    REG_SPACING: spacing_q <= pwdata[30:0];
                    REG_ORIGIN:  origin_q <= pwdata;
                    default:     ;
                endcase
            end
            if (start && !busy)
                level_queue.push_back(predict_level(index_x, index_y, index_z));
            if (done)
            begin
                if (level_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result level %h sat %b",
                             $time, level_value, saturated);
                end
                else
                begin
                    exp_res = level_queue.pop_front();
                    if (level_value !== exp_res.level)
                    begin
                        fail_count++;
                        $display("%0t: level expected %h actual %h",
                                 $time, exp_res.level, level_value);
                    end
                    if (saturated !== exp_res.sat)
                    begin
                        fail_count++;
                        $display("%0t: saturated expected %b actual %b",
                                 $time, exp_res.sat, saturated);
                    end
                end
            end
        end
        pending <= level_queue.size();
    end

    initial fail_count = 0;

endmodule

FILE: verif/tb.sv
// Top of the testbench: clock, reset, register setup and item stimulus.
`timescale 1ns / 1ps
module tb;
    import gsd_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [IDX_W-1:0]     index_x, index_y, index_z;
    logic                 done;
    logic [OUT_W-1:0]     level_value;
    logic                 saturated;
    logic                 psel, penable, pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [CFG_DW-1:0]    pwdata;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    bit                   gaps_on;

    grid_signed_distance_eval_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .index_x(index_x), .index_y(index_y), .index_z(index_z),
        .done(done), .level_value(level_value), .saturated(saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gsd_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .index_x(index_x), .index_y(index_y), .index_z(index_z),
        .done(done), .level_value(level_value), .saturated(saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_shape(input logic [2:0] mode, input logic [31:0] size,
                             input logic [31:0] spacing, input logic [31:0] origin);
        write_reg(REG_MODE, {29'd0, mode});
        write_reg(REG_SIZE, size);
        write_reg(REG_SPACING, spacing);
        write_reg(REG_ORIGIN, origin);
    endtask

    // Waits for every outstanding result, then a margin past the pipeline depth.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    task automatic send_point(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
                              input logic [IDX_W-1:0] z);
        int r;
        start <= 1'b1;
        index_x <= x;
        index_y <= y;
        index_z <= z;
        do
            @(posedge clk);
        while (busy);
        r = $urandom_range(0, 99);
        if (gaps_on && r >= 60)
        begin
            start <= 1'b0;
            repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40))
                @(posedge clk);
        end
    endtask

    function automatic logic [IDX_W-1:0] rand_index();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return IDX_W'($urandom_range(0, 8));
            default: return IDX_W'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return -$urandom_range(0, 32'h0040_0000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [2:0] mode;
        rst_n = 1'b0;
        start = 1'b0;
        index_x = '0;
        index_y = '0;
        index_z = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gaps_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings first, then every mode code, the unused ones too, at one common setting.
        send_point(0, 0, 0);
        send_point(1023, 1023, 1023);
        send_point(1, 2, 3);
        drain_results();
        for (int m = 0; m < 8; m++)
        begin
            set_shape(3'(m), 32'h0000_8000, 32'h0000_4000, 32'hFFFE_0000);
            send_point(0, 0, 0);
            send_point(8, 0, 4);
            drain_results();
        end
        // Large values that saturate, and a zero spacing.
        set_shape(MODE_SPHERE, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(1023, 1023, 1023);
        drain_results();
        set_shape(MODE_ELLIPSOID, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000);
        send_point(1023, 5, 0);
        drain_results();
        set_shape(MODE_TORUS, 32'h0000_1000, 32'h0000_0800, 32'd0);
        send_point(3, 1, 7);
        send_point(0, 1023, 0);
        drain_results();

        for (int phase = 0; phase < 20; phase++)
        begin
            mode = (phase < 15) ? 3'(phase % 5) : 3'($urandom_range(0, 7));
            gaps_on = (phase % 4) != 3;
            set_shape(mode, rand_size(),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0003_0000),
                      rand_origin());
            repeat (55)
                send_point(rand_index(), rand_index(), rand_index());
            drain_results();
        end

        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

endmodule
